FILE: sv/wmo_pkg.sv
// ----------------------------------------------------------------------------
// wmo_pkg
// Shared types, field widths and codes for the waveform min/max overview unit.
// ----------------------------------------------------------------------------
package wmo_pkg;

  localparam int unsigned ColumnsDefault = 128;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned LevelCntW      = $clog2(QueueDepth + 1);

  localparam int unsigned FrameW    = 24;
  localparam int unsigned SampleW   = 24;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned SelectW   = 7;
  localparam int unsigned ReadyW    = 8;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 24;

  localparam logic [FrameW-1:0] FrameCountReset = 24'd1;

  typedef enum logic [1:0] {
    CmdRestart = 2'd0,
    CmdFrame   = 2'd1,
    CmdRead    = 2'd2,
    CmdNop     = 2'd3
  } wmo_cmd_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgFrameCount = 2'd0,
    CfgStereoMode = 2'd1
  } wmo_cfg_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
    logic [SelectW-1:0]        column_select;
  } wmo_in_t;

  typedef struct packed {
    logic signed [LevelW-1:0] column_low;
    logic signed [LevelW-1:0] column_high;
    logic [LevelW-1:0]        peak_level;
    logic [ReadyW-1:0]        columns_ready;
    logic                     build_done;
  } wmo_out_t;

  // Classified command as handed from the front to the back
  typedef struct packed {
    wmo_cmd_e                 cmd;
    logic signed [LevelW-1:0] left;
    logic signed [LevelW-1:0] right;
    logic [SelectW-1:0]       select;
  } wmo_op_t;

  // Column count reported once the build is complete
  function automatic logic [ReadyW-1:0] ready_full(input int unsigned cols);
    logic [31:0] c;
    c = 32'(cols);
    if (c > 32'd255) begin
      return 8'd255;
    end
    return c[ReadyW-1:0];
  endfunction

endpackage

FILE: sv/wmo_fifo.sv
// ----------------------------------------------------------------------------
// wmo_fifo
// Small register queue with fill level, used between front, back and output.
// ----------------------------------------------------------------------------
module wmo_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  T                             data_i,
  input  logic                         pop_i,
  output T                             data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(Depth+1)-1:0]   level_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign level_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/wmo_front.sv
// ----------------------------------------------------------------------------
// wmo_front
// Input side: takes commands, converts Q1.23 samples to 16 bits, resolves mono.
// ----------------------------------------------------------------------------
module wmo_front (
  input  logic              push_i,
  input  logic              q_full_i,
  input  logic              stereo_mode_i,
  input  wmo_pkg::wmo_in_t  item_i,
  output logic              full_o,
  output logic              q_push_o,
  output wmo_pkg::wmo_op_t  op_o
);
  import wmo_pkg::*;

  // Positive: round(s * 32767 / 2^23). Negative: -round(|s| / 256).
  function automatic logic signed [LevelW-1:0] q23_to_s16(input logic [SampleW-1:0] v);
    logic [38:0]        prod;
    logic [SampleW-1:0] mag;
    logic [SampleW:0]   rounded;
    logic [16:0]        mag17;
    logic [16:0]        neg17;
    prod    = 39'(v[SampleW-2:0]) * 39'd32767 + 39'd4194304;
    mag     = SampleW'(0) - v;
    rounded = 25'(mag) + 25'd128;
    mag17   = rounded[24:8];
    neg17   = 17'd0 - mag17;
    if (v[SampleW-1]) begin
      return $signed(neg17[15:0]);
    end
    return $signed(prod[38:23]);
  endfunction

  logic signed [LevelW-1:0] left_conv, right_conv;

  assign left_conv  = q23_to_s16(item_i.left_sample);
  assign right_conv = q23_to_s16(item_i.right_sample);

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    op_o.cmd    = wmo_cmd_e'(item_i.cmd);
    op_o.left   = left_conv;
    op_o.right  = stereo_mode_i ? right_conv : left_conv;
    op_o.select = item_i.column_select;
  end

endmodule

FILE: sv/wmo_back.sv
// ----------------------------------------------------------------------------
// wmo_back
// Execution side: column divider, min/max column memory, peak and progress.
// ----------------------------------------------------------------------------
module wmo_back #(
  parameter int unsigned Columns = wmo_pkg::ColumnsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [wmo_pkg::FrameW-1:0]        frame_count_i,
  input  logic                              op_valid_i,
  input  wmo_pkg::wmo_op_t                  op_i,
  output logic                              op_pop_o,
  input  logic [wmo_pkg::LevelCntW-1:0]     res_level_i,
  output logic                              res_push_o,
  output wmo_pkg::wmo_out_t                 res_o
);
  import wmo_pkg::*;

  localparam int unsigned CW    = (Columns > 1) ? $clog2(Columns) : 1;
  localparam int unsigned PW    = FrameW + CW;
  localparam int unsigned StepW = (CW > 1) ? $clog2(CW) : 1;
  localparam int unsigned SelW  = (CW > SelectW) ? CW : SelectW;
  localparam logic [ReadyW-1:0] ReadyFull = ready_full(Columns);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StFetch,
    StUpdate,
    StReadWait
  } state_e;

  state_e                   state_q;
  logic [FrameW-1:0]        next_frame_q;
  logic [LevelW-1:0]        peak_q;
  logic [ReadyW-1:0]        ready_q;
  logic                     done_q;
  logic [Columns-1:0]       seen_q;
  logic signed [LevelW-1:0] lo_q, hi_q;
  logic [FrameW-1:0]        rem0_q, rem1_q;
  logic [CW-1:0]            low0_q, low1_q;
  logic [CW-1:0]            quo0_q, quo1_q;
  logic [StepW-1:0]         step_q;
  logic                     res_push_q, res_push_d;
  wmo_out_t                 res_q, res_d;

  logic signed [LevelW-1:0] min_mem_q [Columns];
  logic signed [LevelW-1:0] max_mem_q [Columns];
  logic signed [LevelW-1:0] rd_min_q, rd_max_q;

  logic                     res_ok, op_pop;
  logic [SelW-1:0]          sel_ext;
  logic [CW-1:0]            sel_idx;
  logic                     sel_ok, sel_hit;
  logic signed [LevelW-1:0] lo_in, hi_in;
  logic [FrameW-1:0]        nf_inc;
  logic [PW-1:0]            prod0, prod1;
  logic [FrameW:0]          r0_ext, r1_ext, sub0, sub1;
  logic                     ge0, ge1;
  logic [FrameW-1:0]        rem0_d, rem1_d;
  logic [CW:0]              quo0_ext, quo1_ext;
  logic                     rd_en, wr_en;
  logic [CW-1:0]            rd_addr;
  logic                     seen_col;
  logic signed [LevelW-1:0] new_min, new_max;
  logic [16:0]              abs_lo17, abs_hi17;
  logic [LevelW-1:0]        abs_lo, abs_hi, peak_d;
  logic                     finish;
  logic [31:0]              quo1_wide;
  logic [ReadyW-1:0]        ready_d;
  wmo_out_t                 status;

  // A slot is claimed in the output queue before an op starts, counting a push in flight
  assign res_ok   = (32'(res_level_i) + 32'(res_push_q)) < QueueDepth;
  assign op_pop   = (state_q == StIdle) && op_valid_i && res_ok;
  assign op_pop_o = op_pop;

  assign res_push_o = res_push_q;
  assign res_o      = res_q;

  assign sel_ext = SelW'(op_i.select);
  assign sel_idx = sel_ext[CW-1:0];
  assign sel_ok  = 32'(op_i.select) < Columns;
  assign sel_hit = sel_ok && seen_q[sel_idx];

  assign lo_in  = (op_i.left < op_i.right) ? op_i.left : op_i.right;
  assign hi_in  = (op_i.left > op_i.right) ? op_i.left : op_i.right;
  assign nf_inc = next_frame_q + 1'b1;

  // Dividends for this frame's column and for the progress count after it
  assign prod0 = PW'(next_frame_q) * PW'(Columns);
  assign prod1 = PW'(nf_inc) * PW'(Columns);

  // Restoring division, one quotient bit per cycle on both dividers
  always_comb begin
    r0_ext   = {rem0_q, low0_q[CW-1]};
    r1_ext   = {rem1_q, low1_q[CW-1]};
    ge0      = r0_ext >= {1'b0, frame_count_i};
    ge1      = r1_ext >= {1'b0, frame_count_i};
    sub0     = r0_ext - {1'b0, frame_count_i};
    sub1     = r1_ext - {1'b0, frame_count_i};
    rem0_d   = ge0 ? sub0[FrameW-1:0] : r0_ext[FrameW-1:0];
    rem1_d   = ge1 ? sub1[FrameW-1:0] : r1_ext[FrameW-1:0];
    quo0_ext = {quo0_q, ge0};
    quo1_ext = {quo1_q, ge1};
  end

  always_comb begin
    seen_col = seen_q[quo0_q];
    new_min  = (seen_col && (rd_min_q < lo_q)) ? rd_min_q : lo_q;
    new_max  = (seen_col && (rd_max_q > hi_q)) ? rd_max_q : hi_q;
    abs_lo17 = lo_q[LevelW-1] ? (17'd0 - 17'(lo_q)) : 17'(lo_q);
    abs_hi17 = hi_q[LevelW-1] ? (17'd0 - 17'(hi_q)) : 17'(hi_q);
    abs_lo   = abs_lo17[LevelW-1:0];
    abs_hi   = abs_hi17[LevelW-1:0];
    peak_d   = peak_q;
    if (abs_lo > peak_d) begin
      peak_d = abs_lo;
    end
    if (abs_hi > peak_d) begin
      peak_d = abs_hi;
    end
    finish    = nf_inc >= frame_count_i;
    quo1_wide = 32'(quo1_q);
    if (finish) begin
      ready_d = ReadyFull;
    end else if (quo1_wide > 32'd255) begin
      ready_d = 8'd255;
    end else begin
      ready_d = quo1_wide[ReadyW-1:0];
    end
  end

  always_comb begin
    status.column_low    = '0;
    status.column_high   = '0;
    status.peak_level    = peak_q;
    status.columns_ready = ready_q;
    status.build_done    = done_q;
  end

  // Result register contents for the op finishing this cycle
  always_comb begin
    res_push_d = 1'b0;
    res_d      = res_q;
    case (state_q)
      StIdle: begin
        if (op_pop) begin
          case (op_i.cmd)
            CmdRestart: begin
              res_d      = '0;
              res_push_d = 1'b1;
            end
            CmdFrame: begin
              if (done_q) begin
                res_d      = status;
                res_push_d = 1'b1;
              end else if (next_frame_q >= frame_count_i) begin
                res_d               = status;
                res_d.columns_ready = ReadyFull;
                res_d.build_done    = 1'b1;
                res_push_d          = 1'b1;
              end
            end
            CmdRead: begin
              if (!sel_hit) begin
                res_d      = status;
                res_push_d = 1'b1;
              end
            end
            default: begin
              res_d      = status;
              res_push_d = 1'b1;
            end
          endcase
        end
      end
      StUpdate: begin
        res_d               = status;
        res_d.peak_level    = peak_d;
        res_d.columns_ready = ready_d;
        res_d.build_done    = finish;
        res_push_d          = 1'b1;
      end
      StReadWait: begin
        res_d             = status;
        res_d.column_low  = rd_min_q;
        res_d.column_high = rd_max_q;
        res_push_d        = 1'b1;
      end
      default: ;
    endcase
  end

  assign rd_en   = (op_pop && (op_i.cmd == CmdRead)) || (state_q == StFetch);
  assign rd_addr = (state_q == StFetch) ? quo0_q : sel_idx;
  assign wr_en   = (state_q == StUpdate);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      min_mem_q[quo0_q] <= new_min;
      max_mem_q[quo0_q] <= new_max;
    end
    if (rd_en) begin
      rd_min_q <= min_mem_q[rd_addr];
      rd_max_q <= max_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      next_frame_q <= '0;
      peak_q       <= '0;
      ready_q      <= '0;
      done_q       <= 1'b0;
      seen_q       <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      rem0_q       <= '0;
      rem1_q       <= '0;
      low0_q       <= '0;
      low1_q       <= '0;
      quo0_q       <= '0;
      quo1_q       <= '0;
      step_q       <= '0;
      res_push_q   <= 1'b0;
      res_q        <= '0;
    end else begin
      res_push_q <= res_push_d;
      res_q      <= res_d;
      case (state_q)
        StIdle: begin
          if (op_pop) begin
            case (op_i.cmd)
              CmdRestart: begin
                seen_q       <= '0;
                next_frame_q <= '0;
                peak_q       <= '0;
                ready_q      <= '0;
                done_q       <= 1'b0;
              end
              CmdFrame: begin
                if (!done_q && (next_frame_q >= frame_count_i)) begin
                  // frame count at or below progress: close the build
                  done_q  <= 1'b1;
                  ready_q <= ReadyFull;
                end else if (!done_q) begin
                  lo_q    <= lo_in;
                  hi_q    <= hi_in;
                  rem0_q  <= prod0[PW-1:CW];
                  rem1_q  <= prod1[PW-1:CW];
                  low0_q  <= prod0[CW-1:0];
                  low1_q  <= prod1[CW-1:0];
                  quo0_q  <= '0;
                  quo1_q  <= '0;
                  step_q  <= '0;
                  state_q <= StDiv;
                end
              end
              CmdRead: begin
                if (sel_hit) begin
                  state_q <= StReadWait;
                end
              end
              default: ;
            endcase
          end
        end
        StDiv: begin
          rem0_q <= rem0_d;
          rem1_q <= rem1_d;
          low0_q <= low0_q << 1;
          low1_q <= low1_q << 1;
          quo0_q <= quo0_ext[CW-1:0];
          quo1_q <= quo1_ext[CW-1:0];
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(CW - 1)) begin
            state_q <= StFetch;
          end
        end
        StFetch: begin
          state_q <= StUpdate;
        end
        StUpdate: begin
          seen_q[quo0_q] <= 1'b1;
          peak_q         <= peak_d;
          next_frame_q   <= nf_inc;
          done_q         <= finish;
          ready_q        <= ready_d;
          state_q        <= StIdle;
        end
        StReadWait: begin
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

FILE: sv/waveform_minmax_overview_unit.sv
// ----------------------------------------------------------------------------
// waveform_minmax_overview_unit
// Min/max display overview builder for one audio sample, queue-style ports.
// ----------------------------------------------------------------------------
// Commands enter a two-entry queue and results leave through another, so the
// input side keeps taking commands while a result waits to be popped. A
// restart, an ignored frame, a no-op or a read of an empty column is answered
// from the idle state, and a read of a filled column passes through a wait
// state for the registered memory read. A frame that is taken into the build
// is loaded, then the restoring divider finds the column and the progress
// count at one quotient bit per cycle, then the min/max column memory is read
// and written. Each command passes through the command queue before the
// execution side takes it.
module waveform_minmax_overview_unit #(
  parameter int unsigned Columns = wmo_pkg::ColumnsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  wmo_pkg::wmo_in_t                 in_item_i,
  output logic                             empty,
  input  logic                             pop,
  output wmo_pkg::wmo_out_t                out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wmo_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [wmo_pkg::CfgDataW-1:0]     cfg_data_i
);
  import wmo_pkg::*;

  logic [FrameW-1:0]    frame_count_q;
  logic                 stereo_mode_q;

  logic                 cmd_q_push, cmd_q_full, cmd_q_empty, cmd_q_pop;
  wmo_op_t              front_op, head_op;
  logic                 res_push;
  wmo_out_t             res_data;
  logic [LevelCntW-1:0] res_level;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FrameCountReset;
      stereo_mode_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgFrameCount: frame_count_q <= cfg_data_i[FrameW-1:0];
        CfgStereoMode: stereo_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  wmo_front u_front (
    .push_i        (push),
    .q_full_i      (cmd_q_full),
    .stereo_mode_i (stereo_mode_q),
    .item_i        (in_item_i),
    .full_o        (full),
    .q_push_o      (cmd_q_push),
    .op_o          (front_op)
  );

  wmo_fifo #(
    .T     (wmo_op_t),
    .Depth (QueueDepth)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_q_push),
    .data_i  (front_op),
    .pop_i   (cmd_q_pop),
    .data_o  (head_op),
    .full_o  (cmd_q_full),
    .empty_o (cmd_q_empty),
    .level_o ()
  );

  wmo_back #(
    .Columns (Columns)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_count_i (frame_count_q),
    .op_valid_i    (!cmd_q_empty),
    .op_i          (head_op),
    .op_pop_o      (cmd_q_pop),
    .res_level_i   (res_level),
    .res_push_o    (res_push),
    .res_o         (res_data)
  );

  wmo_fifo #(
    .T     (wmo_out_t),
    .Depth (QueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .full_o  (),
    .empty_o (empty),
    .level_o (res_level)
  );

endmodule

FILE: sv/wmo_port_checker.sv
// ----------------------------------------------------------------------------
// wmo_port_checker
// Port-level checks on the result side of the overview unit, bound to the top.
// ----------------------------------------------------------------------------
module wmo_port_checker #(
  parameter int unsigned Columns = wmo_pkg::ColumnsDefault
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input wmo_pkg::wmo_out_t out_item_o
);
  import wmo_pkg::*;

  localparam logic [ReadyW-1:0] ReadyFull = ready_full(Columns);

  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.build_done) |-> (out_item_o.columns_ready == ReadyFull))
    else $error("finished build must report all columns ready");

  a_ready_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.build_done) |-> (32'(out_item_o.columns_ready) < Columns))
    else $error("columns ready reached the column count before the build finished");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.peak_level <= 16'd32768))
    else $error("peak level above full scale");

  a_low_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.column_low <= out_item_o.column_high))
    else $error("column minimum above column maximum");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed before transfer");

endmodule

bind waveform_minmax_overview_unit wmo_port_checker #(.Columns(Columns)) u_port_checker (.*);

FILE: tb/sv/wmo_overview_checker.sv
// ----------------------------------------------------------------------------
// wmo_overview_checker
// Watches the command, result and register channels of the overview unit,
// predicts every result from its own copy of the column store and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmo_overview_checker #(
  parameter int unsigned Columns = wmo_pkg::ColumnsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  logic                          full,
  input  wmo_pkg::wmo_in_t              in_item_i,
  input  logic                          empty,
  input  logic                          pop,
  input  wmo_pkg::wmo_out_t             out_item_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [wmo_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [wmo_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            checked_o,
  output logic [Columns-1:0]            col_written_o
);
  import wmo_pkg::*;

  localparam int ReportLimit = 10;

  // predicted column store and build progress
  logic signed [LevelW-1:0] col_low_mem  [Columns];
  logic signed [LevelW-1:0] col_high_mem [Columns];
  logic [Columns-1:0]       col_touched;
  logic [Columns-1:0]       col_written;
  logic [FrameW-1:0]        frame_pos;
  logic [LevelW-1:0]        peak_abs;
  logic [ReadyW-1:0]        ready_cols;
  logic                     build_complete;

  logic [FrameW-1:0]        cfg_frames;
  logic                     cfg_stereo;

  wmo_out_t expected_results[$];
  int       mismatches = 0;
  int       compared   = 0;

  // Q1.23 to signed 16 bit, round to nearest on the positive side
  function automatic int to_level(input logic signed [SampleW-1:0] s);
    longint v;
    v = s;
    if (v >= 0) begin
      return int'((v * 32767 + 4194304) >>> 23);
    end
    if (v == -8388608) begin
      return -32768;
    end
    return -int'((-v + 128) >>> 8);
  endfunction

  function automatic int magnitude(input int x);
    return (x < 0) ? -x : x;
  endfunction

  task automatic mark_complete();
    build_complete = 1'b1;
    ready_cols     = (Columns > 255) ? 8'd255 : ReadyW'(Columns);
  endtask

  task automatic take_frame(input wmo_in_t it);
    int     lv, rv, lo, hi, col;
    longint ratio;
    if (build_complete) begin
      return;
    end
    // frame count at or under the current position: nothing to take
    if (frame_pos >= cfg_frames) begin
      mark_complete();
      return;
    end
    ratio = longint'(frame_pos) * Columns / longint'(cfg_frames);
    col   = (ratio >= Columns) ? int'(Columns) - 1 : int'(ratio);
    lv    = to_level(it.left_sample);
    rv    = cfg_stereo ? to_level(it.right_sample) : lv;
    lo    = (lv < rv) ? lv : rv;
    hi    = (lv > rv) ? lv : rv;
    if (!col_touched[col]) begin
      col_touched[col]  = 1'b1;
      col_low_mem[col]  = LevelW'(lo);
      col_high_mem[col] = LevelW'(hi);
    end else begin
      if (lo < int'(col_low_mem[col])) col_low_mem[col] = LevelW'(lo);
      if (hi > int'(col_high_mem[col])) col_high_mem[col] = LevelW'(hi);
    end
    col_written[col] = 1'b1;
    if (magnitude(lo) > int'(peak_abs)) peak_abs = LevelW'(magnitude(lo));
    if (magnitude(hi) > int'(peak_abs)) peak_abs = LevelW'(magnitude(hi));
    frame_pos = frame_pos + 1'b1;
    if (frame_pos >= cfg_frames) begin
      mark_complete();
    end else begin
      ratio = longint'(frame_pos) * Columns / longint'(cfg_frames);
      if (ratio > Columns) ratio = Columns;
      if (ratio > 255) ratio = 255;
      ready_cols = ReadyW'(ratio);
    end
  endtask

  task automatic apply_command(input wmo_in_t it, output wmo_out_t res);
    logic signed [LevelW-1:0] lo, hi;
    lo = '0;
    hi = '0;
    case (wmo_cmd_e'(it.cmd))
      CmdRestart: begin
        col_touched    = '0;
        frame_pos      = '0;
        peak_abs       = '0;
        ready_cols     = '0;
        build_complete = 1'b0;
      end
      CmdFrame: take_frame(it);
      CmdRead: begin
        if (int'(it.column_select) < Columns && col_touched[it.column_select]) begin
          lo = col_low_mem[it.column_select];
          hi = col_high_mem[it.column_select];
        end
      end
      default: ;
    endcase
    res.column_low    = lo;
    res.column_high   = hi;
    res.peak_level    = peak_abs;
    res.columns_ready = ready_cols;
    res.build_done    = build_complete;
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("%0t: result %0d, %s: expected %0d, got %0d", $realtime, compared, what,
               want, got);
    end
  endtask

  task automatic check_result(input wmo_out_t got);
    wmo_out_t want;
    compared++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("%0t: result %0d popped with no command outstanding", $realtime, compared);
      end
      return;
    end
    want = expected_results.pop_front();
    if (got.column_low !== want.column_low)
      flag_mismatch("column_low", int'(want.column_low), int'(got.column_low));
    if (got.column_high !== want.column_high)
      flag_mismatch("column_high", int'(want.column_high), int'(got.column_high));
    if (got.peak_level !== want.peak_level)
      flag_mismatch("peak_level", int'(want.peak_level), int'(got.peak_level));
    if (got.columns_ready !== want.columns_ready)
      flag_mismatch("columns_ready", int'(want.columns_ready), int'(got.columns_ready));
    if (got.build_done !== want.build_done)
      flag_mismatch("build_done", int'(want.build_done), int'(got.build_done));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    wmo_out_t want;
    if (!rst_ni) begin
      col_touched    = '0;
      col_written    = '0;
      frame_pos      = '0;
      peak_abs       = '0;
      ready_cols     = '0;
      build_complete = 1'b0;
      cfg_frames     = FrameCountReset;
      cfg_stereo     = 1'b1;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (wmo_cfg_e'(cfg_index_i))
          CfgFrameCount: cfg_frames = cfg_data_i[FrameW-1:0];
          CfgStereoMode: cfg_stereo = cfg_data_i[0];
          default: ;
        endcase
      end
      // a result never leaves in the cycle its command enters, so pop first
      if (pop && !empty) begin
        check_result(out_item_i);
      end
      if (push && !full) begin
        apply_command(in_item_i, want);
        expected_results.push_back(want);
      end
    end
    pending_o     <= expected_results.size();
    fail_cnt_o    <= mismatches;
    checked_o     <= compared;
    col_written_o <= col_written;
  end

endmodule

FILE: tb/sv/tb_waveform_minmax_overview_unit.sv
// ----------------------------------------------------------------------------
// tb_waveform_minmax_overview_unit
// Drives restarts, frames and column reads through the overview unit under
// random idling and back-pressure, across frame counts and channel modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_waveform_minmax_overview_unit;
  import wmo_pkg::*;

  localparam int     Columns      = int'(ColumnsDefault);
  localparam int     RandomItems  = 690;
  localparam int     SteadyItems  = 610;
  localparam int     StallCycles  = 160;
  localparam int     SettleCycles = 24;
  localparam longint CycleLimit   = 500000;

  localparam logic [CfgIndexW-1:0]      CfgSpareIndex = 2'd3;
  localparam logic signed [SampleW-1:0] SampleMax     = 24'sh7FFFFF;
  localparam logic signed [SampleW-1:0] SampleMin     = 24'sh800000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  wmo_in_t              in_item;
  logic                 empty;
  logic                 pop;
  wmo_out_t             out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  int                   fail_cnt;
  int                   pending_cnt;
  int                   checked_cnt;
  logic [Columns-1:0]   col_written;

  int     sent_cnt      = 0;
  int     frame_cnt     = 0;
  int     read_cnt      = 0;
  int     restart_cnt   = 0;
  int     other_cnt     = 0;
  int     reg_write_cnt = 0;
  logic   steady        = 1'b0;  // no idling on either side once set
  logic   stall_req     = 1'b0;
  longint cycle_cnt     = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  waveform_minmax_overview_unit #(
    .Columns(Columns)
  ) DUT (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .in_item_i  (in_item),
    .empty,
    .pop,
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  wmo_overview_checker #(
    .Columns(Columns)
  ) u_checker (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .in_item_i    (in_item),
    .empty,
    .pop,
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending_cnt),
    .checked_o    (checked_cnt),
    .col_written_o(col_written)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[waveform_minmax_overview_unit] ERROR");
      $finish;
    end
  end

  // result side: random pop bursts plus one long hold-off on request
  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        pop <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
        stall_req = 1'b0;
        pop <= 1'b1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic wmo_in_t make_item(input wmo_cmd_e op,
                                        input logic signed [SampleW-1:0] l,
                                        input logic signed [SampleW-1:0] r,
                                        input logic [SelectW-1:0] sel);
    wmo_in_t it;
    it.cmd           = op;
    it.left_sample   = l;
    it.right_sample  = r;
    it.column_select = sel;
    return it;
  endfunction

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 6))
      0: return SampleMax - SampleW'($urandom_range(0, 4095));
      1: return SampleMin + SampleW'($urandom_range(0, 4095));
      2: return SampleW'($urandom_range(0, 1023)) - 24'sd512;
      3: begin
        case ($urandom_range(0, 5))
          0: return SampleMax;
          1: return SampleMin;
          2: return 24'sd0;
          3: return -24'sd1;
          4: return -24'sd129;
          default: return 24'sd128;
        endcase
      end
      default: return SampleW'($urandom);
    endcase
  endfunction

  // only columns that have held data at some point may be read
  function automatic int pick_column();
    int start;
    start = $urandom_range(0, Columns - 1);
    for (int k = 0; k < Columns; k++) begin
      if (col_written[(start + k) % Columns]) return (start + k) % Columns;
    end
    return -1;
  endfunction

  function automatic wmo_in_t random_item();
    int       roll;
    int       sel;
    wmo_cmd_e op;
    roll = $urandom_range(0, 99);
    if (roll < 70) op = CmdFrame;
    else if (roll < 91) op = CmdRead;
    else if (roll < 95) op = CmdRestart;
    else op = CmdNop;
    sel = pick_column();
    if (op == CmdRead && sel < 0) op = CmdFrame;
    if (op != CmdRead) sel = $urandom_range(0, Columns - 1);
    return make_item(op, rand_sample(), rand_sample(), SelectW'(sel));
  endfunction

  function automatic logic [CfgDataW-1:0] pick_frame_count();
    case ($urandom_range(0, 9))
      0: return 24'd1;
      1: return CfgDataW'($urandom_range(2, 16));
      2, 3, 4: return CfgDataW'($urandom_range(17, 100));
      5: return CfgDataW'(Columns);
      6: return CfgDataW'(Columns - 1 + 2 * $urandom_range(0, 1));
      7: return CfgDataW'($urandom_range(101, 300));
      8: return 24'hFFFFFF - CfgDataW'($urandom_range(0, 2));
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  task automatic send_cmd(input wmo_in_t it);
    logic go;
    if (!steady && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk_i);
      go = !full;
      @(posedge clk_i);
    end while (!go);
    sent_cnt++;
    case (wmo_cmd_e'(it.cmd))
      CmdFrame:   frame_cnt++;
      CmdRead:    read_cnt++;
      CmdRestart: restart_cnt++;
      default:    other_cnt++;
    endcase
  endtask

  // stop offering and wait until every result has been popped
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    logic go;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk_i);
      go = cfg_ready;
      @(posedge clk_i);
    end while (!go);
    reg_write_cnt++;
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] frames, input logic stereo);
    logic [CfgDataW-2:0] pad;
    pad = (CfgDataW - 1)'($urandom);
    write_reg(CfgFrameCount, frames);
    write_reg(CfgStereoMode, {pad, stereo});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int start_cnt;
    push      <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_ni    <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stereo build over 8 frames: conversion corners, reads, late frame
    program_regs(24'd8, 1'b1);
    send_cmd(make_item(CmdFrame, SampleMax, SampleMin, 7'h7F));
    send_cmd(make_item(CmdFrame, 24'sd0, -24'sd1, 7'h00));
    send_cmd(make_item(CmdFrame, -24'sd129, 24'sd128, 7'h55));
    send_cmd(make_item(CmdFrame, 24'sd1, -24'sd128, 7'h2A));
    send_cmd(make_item(CmdRead, 24'sd0, 24'sd0, 7'd0));
    send_cmd(make_item(CmdRead, SampleMax, SampleMin, 7'd16));
    send_cmd(make_item(CmdNop, SampleMin, SampleMax, 7'h7F));
    repeat (4) send_cmd(make_item(CmdFrame, rand_sample(), rand_sample(), 7'd0));
    send_cmd(make_item(CmdFrame, SampleMin, SampleMin, 7'd0));  // after completion
    send_cmd(make_item(CmdRead, 24'sd0, 24'sd0, 7'd64));
    send_cmd(make_item(CmdRestart, SampleMax, SampleMax, 7'h7F));
    send_cmd(make_item(CmdRead, 24'sd0, 24'sd0, 7'd0));         // empty column

    // mono, then frame count lowered under the current position
    drain();
    program_regs(24'd4, 1'b0);
    send_cmd(make_item(CmdFrame, 24'sd4194304, SampleMin, 7'd3));
    send_cmd(make_item(CmdFrame, -24'sd300000, SampleMax, 7'd9));
    drain();
    program_regs(24'd1, 1'b0);
    send_cmd(make_item(CmdFrame, SampleMax, SampleMax, 7'd0));
    send_cmd(make_item(CmdRead, 24'sd0, 24'sd0, 7'd32));

    // zero frame count, then the largest one and a register past the list
    drain();
    program_regs(24'd0, 1'b1);
    send_cmd(make_item(CmdRestart, 24'sd0, 24'sd0, 7'd0));
    send_cmd(make_item(CmdFrame, SampleMax, SampleMin, 7'd0));
    drain();
    write_reg(CfgSpareIndex, 24'hFFFFFF);
    program_regs(24'hFFFFFF, 1'b1);
    send_cmd(make_item(CmdRestart, 24'sd0, 24'sd0, 7'd0));
    send_cmd(make_item(CmdFrame, rand_sample(), rand_sample(), 7'd0));
    send_cmd(make_item(CmdFrame, rand_sample(), rand_sample(), 7'd0));
    send_cmd(make_item(CmdRead, 24'sd0, 24'sd0, 7'd0));

    // random builds: each phase reprograms while idle, mostly from a restart
    phase     = 0;
    start_cnt = sent_cnt;
    while (sent_cnt - start_cnt < RandomItems) begin
      drain();
      program_regs(pick_frame_count(), 1'($urandom));
      if (phase == 2) stall_req = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        send_cmd(make_item(CmdRestart, rand_sample(), rand_sample(),
                           SelectW'($urandom)));
      end
      repeat ($urandom_range(20, 110)) send_cmd(random_item());
      if (sent_cnt - start_cnt >= SteadyItems) steady = 1'b1;
      phase++;
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d commands: %0d frames, %0d column reads, %0d restarts, %0d no-ops",
             sent_cnt, frame_cnt, read_cnt, restart_cnt, other_cnt);
    $display("%0d register transfers over %0d random phases, %0d results compared",
             reg_write_cnt, phase, checked_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("[waveform_minmax_overview_unit] OK");
    end else begin
      $display("[waveform_minmax_overview_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/wmo_pkg.sv
sv/wmo_fifo.sv
sv/wmo_front.sv
sv/wmo_back.sv
sv/waveform_minmax_overview_unit.sv
sv/wmo_port_checker.sv
tb/sv/wmo_overview_checker.sv
tb/sv/tb_waveform_minmax_overview_unit.sv
